// ===== hdl/ellrast_pkg.sv =====
// Shared types and constants for the ellipse outline rasterizer.
// Used by ellrast_core and the ellipse_outline_rasterizer top level.
`default_nettype none

package ellrast_pkg;

  localparam int COORD_W = 8;
  localparam int AXIS_W  = 7;
  localparam int ERR_W   = 26;
  localparam int SQ_W    = 14;
  localparam int MAX_RES = 4;

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Pixel operations
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_INVERT = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_PIXEL  = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // Configuration register indexes
  localparam logic CFG_DISPLAY_WIDTH  = 1'b0;
  localparam logic CFG_DISPLAY_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_QUAD = 2'd1,
    PH_TIP  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [1:0]         op;
    logic [1:0]         status;
    logic               last;
    logic               done;
  } res_t;

  typedef struct packed {
    logic [2:0]           count;
    res_t [MAX_RES-1:0]   res;
  } batch_t;

endpackage

`default_nettype wire

// ===== hdl/ellrast_core.sv =====
// Ellipse stepping state and the per-item result generator.
// Depends on ellrast_pkg; the top level captures the result batch.
`default_nettype none

module ellrast_core
  import ellrast_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire logic               command,
  input  wire logic [COORD_W-1:0] center_x,
  input  wire logic [COORD_W-1:0] center_y,
  input  wire logic [AXIS_W-1:0]  semi_a,
  input  wire logic [AXIS_W-1:0]  semi_b,
  input  wire logic [1:0]         draw_op,
  input  wire logic [7:0]         disp_w,
  input  wire logic [7:0]         disp_h,
  output batch_t                  batch,
  output logic                    init_busy
);

  phase_t phase_r, phase_nxt;
  logic   init_r, init_nxt;

  logic        [COORD_W-1:0] cx_r, cy_r;
  logic        [AXIS_W-1:0]  sa_r;
  logic        [1:0]         op_r;
  logic        [7:0]         dx_r;
  logic signed [7:0]         dy_r;
  logic signed [ERR_W-1:0]   e_r, p_r, q_r;
  logic        [SQ_W-1:0]    a2_r, b2_r;
  logic signed [16:0]        t_r;

  // Start checks
  logic [1:0] op_fix;
  logic       start_ok;
  logic [8:0] right_w, bottom_w;
  assign op_fix   = (draw_op == OP_UNUSED) ? OP_SET : draw_op;
  assign right_w  = {1'b0, center_x} + {2'b0, semi_a};
  assign bottom_w = {1'b0, center_y} + {2'b0, semi_b};
  assign start_ok = (right_w < {1'b0, disp_w}) && (center_y < disp_h) &&
                    (center_x < disp_w) && (center_y >= {1'b0, semi_b}) &&
                    (center_x >= {1'b0, semi_a}) && (bottom_w < {1'b0, disp_h});

  // Start products, all independent of each other.
  logic        [SQ_W-1:0] a2_w, b2_w;
  logic signed [8:0]      bm_w;
  logic signed [16:0]     t_w;
  assign a2_w = {7'd0, semi_a} * {7'd0, semi_a};
  assign b2_w = {7'd0, semi_b} * {7'd0, semi_b};
  assign bm_w = $signed({1'b0, semi_b, 1'b0}) - 9'sd1;
  assign t_w  = $signed({10'd0, semi_a}) * $signed({{8{bm_w[8]}}, bm_w});

  // The cycle after an accepted start finishes the initial error term.
  logic signed [ERR_W-1:0] q_fix, e_fix;
  assign q_fix = $signed({19'd0, sa_r}) * $signed({{9{t_r[16]}}, t_r});
  assign e_fix = $signed({12'd0, b2_r}) - q_fix;

  // Quadrant step. p holds (2dx+1)*b^2 and q holds (2dy-1)*a^2.
  logic signed [27:0] e2_w, p_w, q_w, ew_w, two_b2, two_a2, e_sum;
  logic               xs, ys, moved, quad_done;
  logic        [7:0]  dx_q, dx_t;
  logic signed [7:0]  dy_q;
  logic               tip_done;
  assign e2_w   = {e_r[ERR_W-1], e_r, 1'b0};
  assign p_w    = {{2{p_r[ERR_W-1]}}, p_r};
  assign q_w    = {{2{q_r[ERR_W-1]}}, q_r};
  assign ew_w   = {{2{e_r[ERR_W-1]}}, e_r};
  assign two_b2 = $signed({13'd0, b2_r, 1'b0});
  assign two_a2 = $signed({13'd0, a2_r, 1'b0});
  assign xs     = e2_w < p_w;
  assign ys     = (e2_w + q_w) > 28'sd0;
  assign moved  = xs || ys;
  assign dx_q   = xs ? dx_r + 8'd1 : dx_r;
  assign dy_q   = ys ? dy_r - 8'sd1 : dy_r;
  assign e_sum  = ew_w + (xs ? p_w + two_b2 : 28'sd0) - (ys ? q_w - two_a2 : 28'sd0);
  assign quad_done = !moved || (dy_q[7] && (dx_q >= {1'b0, sa_r}));
  assign dx_t     = dx_r + 8'd1;
  assign tip_done = dx_t >= {1'b0, sa_r};

  // Mirrored coordinates wrap modulo the coordinate width.
  logic [COORD_W-1:0] xp, xm, yp, ym, xtp, xtm;
  assign xp  = cx_r + dx_r;
  assign xm  = cx_r - dx_r;
  assign yp  = cy_r + dy_r;
  assign ym  = cy_r - dy_r;
  assign xtp = cx_r + dx_t;
  assign xtm = cx_r - dx_t;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    init_nxt  = 1'b0;
    if (take) begin
      if (command == CMD_START) begin
        phase_nxt = start_ok ? PH_QUAD : PH_IDLE;
        init_nxt  = start_ok;
      end else begin
        case (phase_r)
          PH_QUAD: begin
            if (quad_done) phase_nxt = PH_IDLE;
            else if (dy_q[7]) phase_nxt = PH_TIP;
          end
          PH_TIP: begin
            if (tip_done) phase_nxt = PH_IDLE;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Result batch for the item on the input
  always_comb begin
    batch = '0;
    if (command == CMD_START) begin
      batch.count         = 3'd1;
      batch.res[0].op     = start_ok ? op_fix : OP_SET;
      batch.res[0].status = start_ok ? ST_ACCEPT : ST_REJECT;
      batch.res[0].last   = 1'b1;
    end else begin
      case (phase_r)
        PH_QUAD: begin
          batch.count       = 3'd4;
          batch.res[0].x    = xp;
          batch.res[0].y    = yp;
          batch.res[1].x    = xm;
          batch.res[1].y    = yp;
          batch.res[2].x    = xm;
          batch.res[2].y    = ym;
          batch.res[3].x    = xp;
          batch.res[3].y    = ym;
          batch.res[0].op   = op_r;
          batch.res[1].op   = op_r;
          batch.res[2].op   = op_r;
          batch.res[3].op   = op_r;
          batch.res[3].last = 1'b1;
          batch.res[3].done = quad_done;
        end
        PH_TIP: begin
          batch.count       = 3'd2;
          batch.res[0].x    = xtp;
          batch.res[0].y    = cy_r;
          batch.res[1].x    = xtm;
          batch.res[1].y    = cy_r;
          batch.res[0].op   = op_r;
          batch.res[1].op   = op_r;
          batch.res[1].last = 1'b1;
          batch.res[1].done = tip_done;
        end
        default: batch.count = 3'd0;
      endcase
    end
  end

  assign init_busy = init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      init_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      init_r  <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (init_r) begin
      q_r <= q_fix;
      e_r <= e_fix;
    end
    if (take) begin
      if (command == CMD_START) begin
        if (start_ok) begin
          cx_r <= center_x;
          cy_r <= center_y;
          sa_r <= semi_a;
          op_r <= op_fix;
          a2_r <= a2_w;
          b2_r <= b2_w;
          t_r  <= t_w;
          p_r  <= $signed({12'd0, b2_w});
          dx_r <= 8'd0;
          dy_r <= $signed({1'b0, semi_b});
        end
      end else if (phase_r == PH_QUAD) begin
        dx_r <= dx_q;
        dy_r <= dy_q;
        e_r  <= e_sum[ERR_W-1:0];
        if (xs) p_r <= p_r + two_b2[ERR_W-1:0];
        if (ys) q_r <= q_r - two_a2[ERR_W-1:0];
      end else if (phase_r == PH_TIP) begin
        dx_r <= dx_t;
      end
    end
  end

  // The tip loop only runs while the offset is short of the semi-axis.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TIP) |-> (dx_r < {1'b0, sa_r}))
    else $error("tip loop entered with offset at or past semi-axis");

  // The error fixup lasts exactly one cycle and follows an accepted start.
  assert property (@(posedge clk) disable iff (!rst_n)
    init_r |=> !init_r)
    else $error("error term fixup held for more than one cycle");

  assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> (phase_r == PH_QUAD))
    else $error("error term fixup outside the quadrant loop");

endmodule

`default_nettype wire

// ===== hdl/ellipse_outline_rasterizer.sv =====
// Ellipse outline rasterizer: input handshake, configuration registers
// and the result queue that serializes each item's pixels. Depends on
// ellrast_pkg and ellrast_core.
// The first result of an item is valid in the cycle after its transfer.
// The output carries one result per cycle while out_tready is high; a quadrant
// step yields four results, a tip step two and a start one, all on the single result port.
// An accepted start holds off the next item while the initial error term
// product completes.
// Reset (synchronous, active low) idles the rasterizer, empties the result
// queue and restores the display size to 100 by 64.
`default_nettype none

module ellipse_outline_rasterizer
  import ellrast_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // center_x, center_y, semi_a, semi_b, draw_op
  input  wire logic        in_tuser,   // command
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // pixel_x, pixel_y, pixel_op, zero fill
  output logic [2:0]       out_tuser,  // status, done_res
  output logic             out_tlast,  // run_last
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0] disp_w_r, disp_h_r;
  batch_t     batch, batch_r;
  logic [2:0] cnt_r;
  logic [1:0] rd_idx_r;
  logic       init_busy;
  logic       in_fire, out_fire;
  res_t       cur;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_w_r <= 8'd100;
      disp_h_r <= 8'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DISPLAY_WIDTH:  disp_w_r <= cfg_data;
        CFG_DISPLAY_HEIGHT: disp_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ellrast_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_fire),
    .command   (in_tuser),
    .center_x  (in_tdata[7:0]),
    .center_y  (in_tdata[15:8]),
    .semi_a    (in_tdata[22:16]),
    .semi_b    (in_tdata[29:23]),
    .draw_op   (in_tdata[31:30]),
    .disp_w    (disp_w_r),
    .disp_h    (disp_h_r),
    .batch     (batch),
    .init_busy (init_busy)
  );

  // A new item may enter while the last queued result is being taken.
  assign in_tready = !init_busy && ((cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready));
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 3'd0;
      rd_idx_r <= 2'd0;
    end else if (in_fire) begin
      cnt_r    <= batch.count;
      rd_idx_r <= 2'd0;
    end else if (out_fire) begin
      cnt_r    <= cnt_r - 3'd1;
      rd_idx_r <= rd_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) batch_r <= batch;
  end

  assign cur        = batch_r.res[rd_idx_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {6'd0, cur.op, cur.y, cur.x};
  assign out_tuser  = {cur.done, cur.status};
  assign out_tlast  = cur.last;

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (batch.count != 3'd0)) |=> out_tvalid)
    else $error("item with results left the queue empty");

  // The last queued result of an item always closes its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (cnt_r == 3'd1)) |-> out_tlast)
    else $error("final result of an item lacks tlast");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (cnt_r != 3'd1)) |-> !out_tlast)
    else $error("tlast raised before the final result of an item");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result queue count out of range");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for ellipse_outline_rasterizer: a queue-fed stream driver,
// a result monitor with its own rasterizer predictor, and display size changes.
// Depends on ellrast_pkg and the rasterizer RTL.

module tb;
  import ellrast_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 3000;  // cycles without any transfer
  localparam int LONG_HOLD   = 400;   // receiver hold-off that backs the block up
  localparam int SEG_ITEMS   = 45;
  localparam int SETTLE      = 4;

  typedef struct {
    logic       cmd;
    logic [7:0] cx;
    logic [7:0] cy;
    logic [6:0] a;
    logic [6:0] b;
    logic [1:0] op;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // center_x, center_y, semi_a, semi_b, draw_op
  logic        in_tuser = 1'b0; // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // pixel_x, pixel_y, pixel_op, zero fill
  logic [2:0]  out_tuser;       // status, done_res
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_DISPLAY_WIDTH;
  logic [7:0]  cfg_data = '0;

  ellipse_outline_rasterizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stim_t stim_queue[$];
  res_t  expected_pixels[$];
  stim_t offered;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int queued_items = 0;
  int items_accepted = 0;
  int starts_accepted = 0;
  int starts_rejected = 0;
  int results_checked = 0;
  int ellipses_finished = 0;
  int quiet_cycles = 0;

  // Predictor copy of the display size and the rasterizer state.
  int     disp_w = 100;
  int     disp_h = 64;
  phase_t ras_phase = PH_IDLE;
  int     ras_dx = 0, ras_dy = 0, ras_err = 0, ras_a2 = 0, ras_b2 = 0;
  int     ras_cx = 0, ras_cy = 0, ras_a = 0;
  logic [1:0] ras_op = OP_SET;

  logic hold_req = 1'b0;
  logic hold_armed = 1'b0;
  int   hold_left = 0;
  wire  hold_active = hold_req && (!hold_armed || hold_left != 0);

  task automatic flag_error(input string msg);
    if (error_count < 60) $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic bit on_display(input int x, input int y);
    return x >= 0 && y >= 0 && x < disp_w && y < disp_h;
  endfunction

  task automatic add_expected(input int x, input int y, input logic [1:0] op,
                              input logic [1:0] st, input bit last, input bit done);
    res_t r;
    r.x = x[7:0];
    r.y = y[7:0];
    r.op = op;
    r.status = st;
    r.last = last;
    r.done = done;
    expected_pixels.push_back(r);
  endtask

  task automatic predict_pixels(input stim_t s);
    int cx, cy, a, b, e2, ox, oy;
    logic [1:0] op;
    bit moved, fin;
    items_accepted++;
    if (s.cmd == CMD_START) begin
      cx = s.cx;
      cy = s.cy;
      a = s.a;
      b = s.b;
      op = (s.op == OP_UNUSED) ? OP_SET : s.op;
      if (!on_display(cx + a, cy) || !on_display(cx, cy - b) ||
          !on_display(cx - a, cy) || !on_display(cx, cy + b)) begin
        ras_phase = PH_IDLE;
        starts_rejected++;
        add_expected(0, 0, OP_SET, ST_REJECT, 1'b1, 1'b0);
      end else begin
        ras_cx = cx;
        ras_cy = cy;
        ras_a = a;
        ras_op = op;
        ras_a2 = a * a;
        ras_b2 = b * b;
        ras_dx = 0;
        ras_dy = b;
        ras_err = ras_b2 - (2 * b - 1) * ras_a2;
        ras_phase = PH_QUAD;
        starts_accepted++;
        add_expected(0, 0, op, ST_ACCEPT, 1'b1, 1'b0);
      end
    end else if (ras_phase == PH_QUAD) begin
      ox = ras_dx;
      oy = ras_dy;
      e2 = 2 * ras_err;
      moved = 1'b0;
      fin = 1'b0;
      if (e2 < (2 * ras_dx + 1) * ras_b2) begin
        ras_dx++;
        ras_err += (2 * ras_dx + 1) * ras_b2;
        moved = 1'b1;
      end
      if (e2 > -(2 * ras_dy - 1) * ras_a2) begin
        ras_dy--;
        ras_err -= (2 * ras_dy - 1) * ras_a2;
        moved = 1'b1;
      end
      // A step that moves neither offset is a single point and ends the ellipse.
      if (!moved) begin
        fin = 1'b1;
        ras_phase = PH_IDLE;
      end else if (ras_dy < 0) begin
        if (ras_dx < ras_a) begin
          ras_phase = PH_TIP;
        end else begin
          fin = 1'b1;
          ras_phase = PH_IDLE;
        end
      end
      if (fin) ellipses_finished++;
      add_expected(ras_cx + ox, ras_cy + oy, ras_op, ST_PIXEL, 1'b0, 1'b0);
      add_expected(ras_cx - ox, ras_cy + oy, ras_op, ST_PIXEL, 1'b0, 1'b0);
      add_expected(ras_cx - ox, ras_cy - oy, ras_op, ST_PIXEL, 1'b0, 1'b0);
      add_expected(ras_cx + ox, ras_cy - oy, ras_op, ST_PIXEL, 1'b1, fin);
    end else if (ras_phase == PH_TIP) begin
      ras_dx++;
      fin = ras_dx >= ras_a;
      if (fin) begin
        ras_phase = PH_IDLE;
        ellipses_finished++;
      end
      add_expected(ras_cx + ras_dx, ras_cy, ras_op, ST_PIXEL, 1'b0, 1'b0);
      add_expected(ras_cx - ras_dx, ras_cy, ras_op, ST_PIXEL, 1'b1, fin);
    end
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got !== want)
      flag_error($sformatf("result %0d: %s is %0d, expected %0d",
                           results_checked, name, got, want));
  endtask

  task automatic check_pixel();
    res_t want;
    results_checked++;
    if (expected_pixels.size() == 0) begin
      flag_error($sformatf("unexpected result x=%0d y=%0d status=%0d",
                           out_tdata[7:0], out_tdata[15:8], out_tuser[1:0]));
    end else begin
      want = expected_pixels.pop_front();
      compare_field("pixel_x", out_tdata[7:0], want.x);
      compare_field("pixel_y", out_tdata[15:8], want.y);
      compare_field("pixel_op", out_tdata[17:16], want.op);
      compare_field("status", out_tuser[1:0], want.status);
      compare_field("done_res", out_tuser[2], want.done);
      compare_field("run_last", out_tlast, want.last);
    end
  endtask

  // Input driver: a new item goes out only once the previous one has transferred.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_pixels(offered);
      if (!in_tvalid || in_tready) begin
        if (stim_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = stim_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {offered.op, offered.b, offered.a, offered.cy, offered.cx};
          in_tuser <= offered.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_pixel();
      out_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_req && !hold_armed) begin
      hold_armed <= 1'b1;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_pixels.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic push_item(input logic cmd, input int cx, input int cy, input int a,
                           input int b, input int op);
    stim_t s;
    s.cmd = cmd;
    s.cx = 8'(cx);
    s.cy = 8'(cy);
    s.a = 7'(a);
    s.b = 7'(b);
    s.op = 2'(op);
    stim_queue.push_back(s);
    queued_items++;
  endtask

  // Step items carry random payload bits; the block must ignore them.
  task automatic push_steps(input int count);
    repeat (count)
      push_item(CMD_STEP, $urandom_range(255), $urandom_range(255), $urandom_range(127),
                $urandom_range(127), $urandom_range(3));
  endtask

  task automatic write_register(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_DISPLAY_WIDTH) disp_w = val;
    else disp_h = val;
  endtask

  // Pauses the sender until every item has transferred and every result arrived.
  task automatic wait_idle();
    while (stim_queue.size() != 0 || in_tvalid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic queue_ellipse();
    int amax, bmax, cap, a, b, cx, cy, roll;
    amax = (disp_w - 1) / 2;
    bmax = (disp_h - 1) / 2;
    cap = ($urandom_range(9) == 0) ? 40 : 10;
    if (amax > cap) amax = cap;
    if (bmax > cap) bmax = cap;
    a = $urandom_range(amax);
    b = $urandom_range(bmax);
    cy = $urandom_range(disp_h - 1 - b, b);
    roll = $urandom_range(99);
    if (roll < 8) begin
      push_item(CMD_START, $urandom_range(255), $urandom_range(255), $urandom_range(127),
                $urandom_range(127), $urandom_range(3));
      push_steps($urandom_range(2));
    end else if (roll < 14) begin
      // Right tip lands one column past the display edge.
      push_item(CMD_START, disp_w - a, cy, a, b, $urandom_range(3));
      push_steps($urandom_range(2));
    end else if (roll < 18) begin
      push_steps($urandom_range(3, 1));
    end else begin
      case ($urandom_range(3))
        0: cx = a;
        1: cx = disp_w - 1 - a;
        default: cx = $urandom_range(disp_w - 1 - a, a);
      endcase
      if ($urandom_range(3) == 0) cy = ($urandom_range(1) == 0) ? b : disp_h - 1 - b;
      push_item(CMD_START, cx, cy, a, b, $urandom_range(3));
      // Most runs go to the end; the rest are abandoned by the next start.
      if ($urandom_range(3) != 0) push_steps(a + b + 3);
      else push_steps($urandom_range(a + b));
    end
  endtask

  task automatic set_display(input int w, input int h);
    write_register(CFG_DISPLAY_WIDTH, 8'(w));
    write_register(CFG_DISPLAY_HEIGHT, 8'(h));
  endtask

  initial begin
    int seg_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part on the reset display size of 100 by 64.
    push_steps(1);                                     // step with nothing running
    push_item(CMD_START, 0, 10, 1, 1, OP_CLEAR);       // left tip off screen
    push_item(CMD_START, 50, 60, 2, 4, OP_INVERT);     // bottom tip off screen
    push_item(CMD_START, 255, 255, 127, 127, OP_UNUSED);
    push_item(CMD_START, 0, 0, 0, 0, OP_INVERT);       // single point
    push_steps(2);
    push_item(CMD_START, 10, 5, 4, 0, OP_SET);         // flat ellipse runs the tip loop
    push_steps(5);
    push_item(CMD_START, 96, 61, 3, 2, OP_UNUSED);     // touches right and bottom edges
    push_steps(7);
    push_item(CMD_START, 50, 30, 20, 20, OP_CLEAR);
    push_steps(2);
    push_item(CMD_START, 0, 3, 0, 3, OP_INVERT);       // abandons the running ellipse
    wait_idle();

    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        0: set_display(100, 64);
        1: set_display(255, 255);
        2: set_display(1, 1);
        6: set_display(100, 64);
        7: set_display(255, 1);
        default: set_display($urandom_range(255, 1), $urandom_range(255, 1));
      endcase
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      seg_start = queued_items;
      if (seg == 1) begin
        push_item(CMD_START, 127, 127, 127, 127, OP_CLEAR);
        push_steps(40);
      end
      if (seg == 4) hold_req = 1'b1;
      while (queued_items - seg_start < SEG_ITEMS) queue_ellipse();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (expected_pixels.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", expected_pixels.size()));
    $display("Covered %0d accepted items: %0d starts accepted, %0d rejected, %0d ellipses",
             items_accepted, starts_accepted, starts_rejected, ellipses_finished);
    $display("completed; %0d results checked over 9 display setting phases, %0d mismatches.",
             results_checked, error_count);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== ellipse_outline_rasterizer.f =====
hdl/ellrast_pkg.sv
hdl/ellrast_core.sv
hdl/ellipse_outline_rasterizer.sv
bench/tb.sv
